/* hw/rtl/rdc_pkg.sv */
// ----------------------------------------------------------------------------
// rdc_pkg
// Types, constants and helpers shared by the radix digit converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

  localparam int VALUE_BITS = 32;
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int ADDR_W     = $clog2(VALUE_BITS);
  localparam int DIV_STEPS  = 8;

  localparam logic [5:0] RADIX_MIN = 6'd2;
  localparam logic [5:0] RADIX_MAX = 6'd36;
  localparam logic [5:0] DIGIT_TEN = 6'd10;
  localparam logic [6:0] CHAR_ZERO = 7'h30;
  localparam logic [6:0] CHAR_A    = 7'h41;

  typedef struct packed {
    logic [31:0] value;
    logic [5:0]  radix;
  } in_t;

  typedef struct packed {
    logic [6:0] digit_char;
    logic       last;
    logic       bad_radix;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BAD,
    ST_DIV_LOAD,
    ST_DIV_WAIT,
    ST_EMIT_RD,
    ST_EMIT_WR
  } state_t;

  function automatic logic [6:0] digit_to_ascii(input logic [5:0] d);
    if (d < DIGIT_TEN) begin
      return CHAR_ZERO + {1'b0, d};
    end else begin
      return CHAR_A + {1'b0, d} - {1'b0, DIGIT_TEN};
    end
  endfunction

endpackage

/* hw/rtl/rdc_div.sv */
// ----------------------------------------------------------------------------
// rdc_div
// Iterative restoring divider, several quotient bits per cycle.
// ----------------------------------------------------------------------------
module rdc_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [rdc_pkg::VALUE_BITS-1:0] dividend,
  input  logic [5:0]                     divisor,
  output logic                           done,
  output logic [rdc_pkg::VALUE_BITS-1:0] quotient,
  output logic [5:0]                     remainder
);

  logic [rdc_pkg::VALUE_BITS-1:0] q_r, q_nxt;
  logic [5:0]                     rem_r, rem_nxt;
  logic [5:0]                     dvs_r;
  logic [rdc_pkg::CNT_W-1:0]      left_r, left_nxt;
  logic                           busy_r, done_r;
  logic [6:0]                     rem7;
  logic                           ge;

  always_comb begin
    q_nxt   = q_r;
    rem_nxt = rem_r;
    rem7    = '0;
    ge      = 1'b0;
    for (int s = 0; s < rdc_pkg::DIV_STEPS; s++) begin
      if (s < int'(left_r)) begin
        rem7 = {rem_nxt, q_nxt[rdc_pkg::VALUE_BITS-1]};
        ge   = (rem7 >= {1'b0, dvs_r});
        if (ge) begin
          rem_nxt = 6'(rem7 - {1'b0, dvs_r});
        end else begin
          rem_nxt = rem7[5:0];
        end
        q_nxt = {q_nxt[rdc_pkg::VALUE_BITS-2:0], ge};
      end
    end
    if (int'(left_r) > rdc_pkg::DIV_STEPS) begin
      left_nxt = left_r - rdc_pkg::CNT_W'(rdc_pkg::DIV_STEPS);
    end else begin
      left_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      left_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        left_r <= rdc_pkg::CNT_W'(rdc_pkg::VALUE_BITS);
      end else if (busy_r) begin
        left_r <= left_nxt;
        if (left_nxt == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

/* hw/rtl/rdc_mem.sv */
// ----------------------------------------------------------------------------
// rdc_mem
// Digit store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rdc_mem (
  input  logic                       clk,
  input  logic                       we,
  input  logic [rdc_pkg::ADDR_W-1:0] waddr,
  input  logic [5:0]                 wdata,
  input  logic                       re,
  input  logic [rdc_pkg::ADDR_W-1:0] raddr,
  output logic [5:0]                 rdata
);

  logic [5:0] mem_r [rdc_pkg::VALUE_BITS];
  logic [5:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/radix_digit_converter.sv */
// ----------------------------------------------------------------------------
// radix_digit_converter
// Converts an unsigned value to ASCII digits in a base from 2 to 36.
// ----------------------------------------------------------------------------
// One item in, one character item out per digit, most significant digit first,
// with last set on the final one. A base outside 2..36 gives a single item
// with digit_char 0 and bad_radix set. Items are handled one at a time: the
// digits are found by repeated division in an iterative divider that retires
// 8 quotient bits per cycle, stored least significant first in a small digit
// memory, then read back from the top, each character taking a read state and
// then an output state because of the memory's registered read. The next item
// is taken once the last character has been loaded into the output register.
module radix_digit_converter (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rdc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output rdc_pkg::out_t out_data
);

  rdc_pkg::state_t state_r, state_nxt;

  logic [rdc_pkg::VALUE_BITS-1:0] rem_val_r, rem_val_nxt;
  logic [5:0]                     radix_r, radix_nxt;
  logic [rdc_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [rdc_pkg::ADDR_W-1:0]     idx_r, idx_nxt;
  logic                           out_valid_r, out_valid_nxt;
  rdc_pkg::out_t                  out_data_r, out_data_nxt;

  logic                           bad;
  logic                           out_free;
  logic                           div_start, div_done;
  logic [rdc_pkg::VALUE_BITS-1:0] div_quot;
  logic [5:0]                     div_rem;
  logic                           mem_we, mem_re;
  logic [5:0]                     mem_rdata;

  assign bad      = !(in_data.radix inside {[rdc_pkg::RADIX_MIN:rdc_pkg::RADIX_MAX]});
  assign out_free = !out_valid_r || !out_stall;

  rdc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (rem_val_r),
    .divisor   (radix_r),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  rdc_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count_r[rdc_pkg::ADDR_W-1:0]),
    .wdata (div_rem),
    .re    (mem_re),
    .raddr (idx_r),
    .rdata (mem_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rdc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = bad ? rdc_pkg::ST_BAD : rdc_pkg::ST_DIV_LOAD;
        end
      end
      rdc_pkg::ST_BAD: begin
        if (out_free) begin
          state_nxt = rdc_pkg::ST_IDLE;
        end
      end
      rdc_pkg::ST_DIV_LOAD: begin
        state_nxt = rdc_pkg::ST_DIV_WAIT;
      end
      rdc_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = (div_quot == '0) ? rdc_pkg::ST_EMIT_RD : rdc_pkg::ST_DIV_LOAD;
        end
      end
      rdc_pkg::ST_EMIT_RD: begin
        state_nxt = rdc_pkg::ST_EMIT_WR;
      end
      rdc_pkg::ST_EMIT_WR: begin
        if (out_free) begin
          state_nxt = (idx_r == '0) ? rdc_pkg::ST_IDLE : rdc_pkg::ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = rdc_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_stall      = (state_r != rdc_pkg::ST_IDLE);
    div_start     = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    rem_val_nxt   = rem_val_r;
    radix_nxt     = radix_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      rdc_pkg::ST_IDLE: begin
        if (in_valid) begin
          rem_val_nxt = bad ? '0 : rdc_pkg::VALUE_BITS'(in_data.value);
          radix_nxt   = in_data.radix;
          count_nxt   = '0;
        end
      end
      rdc_pkg::ST_BAD: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.digit_char = '0;
          out_data_nxt.last       = 1'b1;
          out_data_nxt.bad_radix  = 1'b1;
        end
      end
      rdc_pkg::ST_DIV_LOAD: begin
        div_start = 1'b1;
      end
      rdc_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          mem_we      = 1'b1;
          rem_val_nxt = div_quot;
          count_nxt   = count_r + 1'b1;
          if (div_quot == '0) begin
            idx_nxt = count_r[rdc_pkg::ADDR_W-1:0];
          end
        end
      end
      rdc_pkg::ST_EMIT_RD: begin
        mem_re = 1'b1;
      end
      rdc_pkg::ST_EMIT_WR: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.digit_char = rdc_pkg::digit_to_ascii(mem_rdata);
          out_data_nxt.last       = (idx_r == '0);
          out_data_nxt.bad_radix  = 1'b0;
          if (idx_r != '0) begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rdc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      rem_val_r   <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      radix_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rem_val_r   <= rem_val_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      radix_r     <= radix_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* tb/radix_digit_converter_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_converter_test
// Sends values with bases (good and bad) into the converter and checks every
// character item against a prediction built from repeated division. Both
// channels idle in random bursts. Midway, the sender holds off until all
// characters have come back. The run finishes with a stretch without idling.
// ----------------------------------------------------------------------------
module radix_digit_converter_test;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 330;
  localparam int CALM_ITEMS   = 40;

  class char_checker;
    rdc_pkg::out_t expected_chars[$];
    int            errors;

    function void expect_digits(rdc_pkg::in_t item);
      logic [31:0]   rest;
      logic [31:0]   base;
      logic [5:0]    digits[$];
      rdc_pkg::out_t ch;
      base = {26'd0, item.radix};
      if (item.radix < rdc_pkg::RADIX_MIN || item.radix > rdc_pkg::RADIX_MAX) begin
        ch.digit_char = 7'd0;
        ch.last       = 1'b1;
        ch.bad_radix  = 1'b1;
        expected_chars.push_back(ch);
      end else begin
        rest = item.value;
        // least significant digit first; zero still yields one digit
        do begin
          digits.push_back(6'(rest % base));
          rest = rest / base;
        end while (rest != 0);
        for (int k = digits.size() - 1; k >= 0; k--) begin
          if (digits[k] < rdc_pkg::DIGIT_TEN) begin
            ch.digit_char = rdc_pkg::CHAR_ZERO + 7'(digits[k]);
          end else begin
            ch.digit_char = rdc_pkg::CHAR_A + 7'(digits[k] - rdc_pkg::DIGIT_TEN);
          end
          ch.last      = (k == 0);
          ch.bad_radix = 1'b0;
          expected_chars.push_back(ch);
        end
      end
    endfunction

    function void check_char(rdc_pkg::out_t got);
      rdc_pkg::out_t want;
      if (expected_chars.size() == 0) begin
        $error("unexpected item: digit_char %h last %b bad_radix %b",
               got.digit_char, got.last, got.bad_radix);
        errors++;
      end else begin
        want = expected_chars.pop_front();
        if (got.digit_char !== want.digit_char) begin
          $error("digit_char: expected %h, actual %h", want.digit_char, got.digit_char);
          errors++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %b, actual %b", want.last, got.last);
          errors++;
        end
        if (got.bad_radix !== want.bad_radix) begin
          $error("bad_radix: expected %b, actual %b", want.bad_radix, got.bad_radix);
          errors++;
        end
      end
    endfunction
  endclass

  logic          clk;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  rdc_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  rdc_pkg::out_t out_data;

  char_checker chk;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int stall_left  = 0;
  int cycle_count = 0;

  radix_digit_converter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      chk.check_char(out_data);
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_item(input logic [31:0] value, input logic [5:0] radix);
    rdc_pkg::in_t item;
    item.value = value;
    item.radix = radix;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    chk.expect_digits(item);
    @(negedge clk);
  endtask

  task automatic drain_chars();
    do @(negedge clk); while (chk.expected_chars.size() != 0);
  endtask

  initial begin
    logic [31:0] value;
    logic [5:0]  radix;
    int          mode;
    chk = new();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    idle_pct  = 20;
    stall_pct = 20;
    send_item(32'd0, 6'd10);
    send_item(32'd0, 6'd2);
    send_item(32'hFFFF_FFFF, 6'd2);
    send_item(32'hFFFF_FFFF, 6'd36);
    send_item(32'hFFFF_FFFF, 6'd16);
    send_item(32'hFFFF_FFFF, 6'd10);
    send_item(32'd1, 6'd2);
    send_item(32'd9, 6'd10);
    send_item(32'd10, 6'd11);
    send_item(32'd35, 6'd36);
    send_item(32'd36, 6'd36);
    send_item(32'd1295, 6'd36);
    send_item(32'hDEAD_BEEF, 6'd16);
    send_item(32'd12345, 6'd8);
    send_item(32'd123, 6'd3);
    send_item(32'h8000_0000, 6'd2);
    send_item(32'h5555_5555, 6'd4);
    send_item(32'hAAAA_AAAA, 6'd2);
    send_item(32'd77, 6'd0);
    send_item(32'd5, 6'd1);
    send_item(32'd7, 6'd37);
    send_item(32'hFFFF_FFFF, 6'd63);
    send_item(32'd0, 6'd63);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= RANDOM_ITEMS - CALM_ITEMS) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else if (n % 50 == 0) begin
        idle_pct  = 25 * $urandom_range(2);
        stall_pct = 25 * $urandom_range(2);
      end
      if (n == RANDOM_ITEMS / 2) begin
        in_valid <= 1'b0;
        drain_chars();
      end
      mode = $urandom_range(3);
      case (mode)
        0: value = $urandom;
        1: value = $urandom >> $urandom_range(31);
        2: value = $urandom_range(1000);
        default: value = $urandom_range(40);
      endcase
      if ($urandom_range(99) < 12) begin
        case ($urandom_range(2))
          0: radix = 6'd0;
          1: radix = 6'd1;
          default: radix = 6'($urandom_range(37, 63));
        endcase
      end else begin
        radix = 6'($urandom_range(2, 36));
      end
      send_item(value, radix);
    end

    in_valid <= 1'b0;
    drain_chars();
    repeat (40) @(negedge clk);
    if (chk.errors == 0 && chk.expected_chars.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
